@@ rtl/mfn_pkg.sv @@
// Package: shared types and constants for the mixed fraction normalizer.
`timescale 1ns / 1ps

package mfn_pkg;

    // Field widths of the stream payloads
    localparam int unsigned NUM_W    = 32;
    localparam int unsigned DEN_W    = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned WHOLE_W  = 32;
    localparam int unsigned RNUM_W   = 31;
    localparam int unsigned RDEN_W   = 32;
    localparam int unsigned IN_TDATA_W  = NUM_W + DEN_W;
    localparam int unsigned OUT_TDATA_W = 1 + WHOLE_W + RNUM_W + RDEN_W;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_NAN   = 3'd0,
        ST_ZERO  = 3'd1,
        ST_WHOLE = 3'd2,
        ST_FRAC  = 3'd3,
        ST_MIXED = 3'd4
    } t_status;

    // Top-level sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_GCD,
        S_RED,
        S_DONE
    } t_state;

endpackage

@@ rtl/mfn_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module mfn_div #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_WIDTH-1:0] i_dividend,
    input  logic [DATA_WIDTH-1:0] i_divisor,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_quot,
    output logic [DATA_WIDTH-1:0] o_rem
);

    localparam int unsigned CW = $clog2(DATA_WIDTH);
    localparam logic [CW-1:0] LAST = CW'(DATA_WIDTH - 1);

    logic [DATA_WIDTH-1:0] r_quo;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_dvs;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DATA_WIDTH:0]   w_shift;
    logic [DATA_WIDTH:0]   w_diff;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign w_shift = {r_rem, r_quo[DATA_WIDTH-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    // Control: busy flag, step counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[DATA_WIDTH]) begin
                r_rem <= w_diff[DATA_WIDTH-1:0];
                r_quo <= {r_quo[DATA_WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DATA_WIDTH-1:0];
                r_quo <= {r_quo[DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

@@ rtl/mfn_gcd.sv @@
// Binary gcd unit: one halving or subtract-and-halve step per cycle.
`timescale 1ns / 1ps

module mfn_gcd #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_gcd
);

    localparam int unsigned KW = $clog2(DATA_WIDTH);

    logic [DATA_WIDTH-1:0] r_a;
    logic [DATA_WIDTH-1:0] r_b;
    logic [KW-1:0]         r_k;
    logic [DATA_WIDTH-1:0] r_g;
    logic                  r_busy;
    logic                  r_done;

    logic [DATA_WIDTH:0]   w_amb;
    logic [DATA_WIDTH:0]   w_bma;

    assign w_amb = {1'b0, r_a} - {1'b0, r_b};
    assign w_bma = {1'b0, r_b} - {1'b0, r_a};

    // Control: runs until both operands meet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_a == r_b)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Stein steps; common factors of two are counted in r_k
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_k <= '0;
        end else if (r_busy) begin
            if (r_a == r_b) begin
                r_g <= r_a << r_k;
            end else if (!r_a[0] && !r_b[0]) begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (!w_amb[DATA_WIDTH]) begin
                r_a <= {1'b0, w_amb[DATA_WIDTH-1:1]};
            end else begin
                r_b <= {1'b0, w_bma[DATA_WIDTH-1:1]};
            end
        end
    end

    assign o_done = r_done;
    assign o_gcd  = r_g;

endmodule

@@ rtl/mixed_fraction_normalize.sv @@
// Top level: signed fraction to mixed number in lowest terms.
// Path, accept to result valid: a zero numerator or denominator goes straight to done,
// a whole-only result follows the quotient divide, otherwise the result follows the
// quotient divide, the binary gcd steps and the reduction divides.
// Throughput: one request in flight; the next is accepted the cycle after the result
// loads into the output register. Reset (synchronous, active low) clears the
// sequencer and output valid.
`timescale 1ns / 1ps

module mixed_fraction_normalize #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // s_axis_tdata: numerator [31:0], denominator [63:32]
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mfn_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // m_axis_tdata: negative [0], whole_part [32:1], rest_numerator [63:33],
    //               rest_denominator [95:64]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mfn_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // m_axis_tuser: status [2:0]
    output logic [mfn_pkg::STATUS_W-1:0]        m_axis_tuser
);

    localparam int unsigned W = DATA_WIDTH;

    mfn_pkg::t_state r_state;
    mfn_pkg::t_state n_state;

    logic                  r_neg;
    logic [W-1:0]          r_ad;
    logic [W-1:0]          r_whole;
    logic [W-1:0]          r_rn;
    logic [W-1:0]          r_rd;
    mfn_pkg::t_status      r_status;

    logic                  r_o_valid;
    logic [mfn_pkg::OUT_TDATA_W-1:0] r_o_data;
    logic [mfn_pkg::STATUS_W-1:0]    r_o_user;

    logic                  w_accept;
    logic                  w_out_load;
    logic [W-1:0]          w_num;
    logic [W-1:0]          w_den;
    logic                  w_num_neg;
    logic                  w_den_neg;
    logic [W-1:0]          w_an;
    logic [W-1:0]          w_ad;
    logic                  w_special;

    logic                  w_div0_start;
    logic [W-1:0]          w_div0_a;
    logic [W-1:0]          w_div0_b;
    logic                  w_div0_done;
    logic [W-1:0]          w_div0_q;
    logic [W-1:0]          w_div0_r;
    logic                  w_div1_start;
    logic                  w_div1_done;
    logic [W-1:0]          w_div1_q;
    logic [W-1:0]          w_div1_r;
    logic                  w_gcd_start;
    logic                  w_gcd_done;
    logic [W-1:0]          w_gcd;

    // Input decode: resize to the working width, exact magnitudes
    assign w_num     = W'(signed'(s_axis_tdata[mfn_pkg::NUM_W-1:0]));
    assign w_den     = W'(signed'(s_axis_tdata[mfn_pkg::IN_TDATA_W-1:mfn_pkg::NUM_W]));
    assign w_num_neg = w_num[W-1];
    assign w_den_neg = w_den[W-1];
    assign w_an      = w_num_neg ? (~w_num + 1'b1) : w_num;
    assign w_ad      = w_den_neg ? (~w_den + 1'b1) : w_den;
    assign w_special = (w_den == '0) || (w_num == '0);

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_load = (r_state == mfn_pkg::S_DONE) && (!r_o_valid || m_axis_tready);

    // Divider 0 serves the quotient divide and the numerator reduction
    assign w_div0_a = (r_state == mfn_pkg::S_IDLE) ? w_an : r_rn;
    assign w_div0_b = (r_state == mfn_pkg::S_IDLE) ? w_ad : w_gcd;

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfn_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and unit starts
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_div0_start  = 1'b0;
        w_div1_start  = 1'b0;
        w_gcd_start   = 1'b0;
        unique case (r_state)
            mfn_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (w_special) begin
                        n_state = mfn_pkg::S_DONE;
                    end else begin
                        w_div0_start = 1'b1;
                        n_state      = mfn_pkg::S_DIV;
                    end
                end
            end
            mfn_pkg::S_DIV: begin
                if (w_div0_done) begin
                    if (w_div0_r == '0) begin
                        n_state = mfn_pkg::S_DONE;
                    end else begin
                        w_gcd_start = 1'b1;
                        n_state     = mfn_pkg::S_GCD;
                    end
                end
            end
            mfn_pkg::S_GCD: begin
                if (w_gcd_done) begin
                    w_div0_start = 1'b1;
                    w_div1_start = 1'b1;
                    n_state      = mfn_pkg::S_RED;
                end
            end
            mfn_pkg::S_RED: begin
                if (w_div0_done && w_div1_done) begin
                    n_state = mfn_pkg::S_DONE;
                end
            end
            mfn_pkg::S_DONE: begin
                if (w_out_load) begin
                    n_state = mfn_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mfn_pkg::S_IDLE;
            end
        endcase
    end

    // Result fields gathered along the way
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ad <= w_ad;
            if (w_den == '0) begin
                r_status <= mfn_pkg::ST_NAN;
            end else begin
                r_status <= mfn_pkg::ST_ZERO;
            end
            r_neg   <= w_special ? 1'b0 : (w_num_neg ^ w_den_neg);
            r_whole <= '0;
            r_rn    <= '0;
            r_rd    <= '0;
        end else if ((r_state == mfn_pkg::S_DIV) && w_div0_done) begin
            r_whole <= w_div0_q;
            r_rn    <= w_div0_r;
            if (w_div0_r == '0) begin
                r_rd     <= W'(1);
                r_status <= mfn_pkg::ST_WHOLE;
            end else if (w_div0_q != '0) begin
                r_status <= mfn_pkg::ST_MIXED;
            end else begin
                r_status <= mfn_pkg::ST_FRAC;
            end
        end else if ((r_state == mfn_pkg::S_RED) && w_div0_done) begin
            r_rn <= w_div0_q;
            r_rd <= w_div1_q;
        end
    end

    // Output register: holds a result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_load) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_user <= r_status;
            r_o_data <= {mfn_pkg::RDEN_W'(r_rd), mfn_pkg::RNUM_W'(r_rn),
                         mfn_pkg::WHOLE_W'(r_whole), r_neg};
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_user;

    // Quotient divide and numerator reduction
    mfn_div #(
        .DATA_WIDTH (W)
    ) u_div0 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div0_start),
        .i_dividend (w_div0_a),
        .i_divisor  (w_div0_b),
        .o_done     (w_div0_done),
        .o_quot     (w_div0_q),
        .o_rem      (w_div0_r)
    );

    // Denominator reduction, in step with divider 0; remainder is zero
    mfn_div #(
        .DATA_WIDTH (W)
    ) u_div1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div1_start),
        .i_dividend (r_ad),
        .i_divisor  (w_gcd),
        .o_done     (w_div1_done),
        .o_quot     (w_div1_q),
        .o_rem      (w_div1_r)
    );

    // gcd of denominator magnitude and remainder
    mfn_gcd #(
        .DATA_WIDTH (W)
    ) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_start),
        .i_a     (r_ad),
        .i_b     (w_div0_r),
        .o_done  (w_gcd_done),
        .o_gcd   (w_gcd)
    );

endmodule
